// ===== rtl/core/tkv_pkg.sv =====
// Shared definitions for the type K voltage-to-temperature converter:
// widths, coefficient ROM, range bounds, divider constants and FSM types.
// No dependencies; used by tkv_mul and thermocouple_k_voltage_to_temp.
package tkv_pkg;

	// field widths
	localparam int X_W      = 17;
	localparam int T_W      = 19;

	// coefficient ROM geometry
	localparam int COEF_W     = 48;
	localparam int ROM_RANGES = 4;
	localparam int ROM_COEFFS = 16;
	localparam int RSEL_W     = 2;
	localparam int CIDX_W     = 4;

	// defaults for the top-level parameters
	localparam int DEF_COEFFS_PER_RANGE = 10;
	localparam int DEF_RANGE_COUNT      = 3;

	// Horner accumulator and shared multiplier
	localparam int ACC_W   = 56;
	localparam int LO_W    = 28;
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// floor divider: sign fold, power-of-two shift, then odd part in 18-bit digits
	localparam int NUM_W       = 73;
	localparam int WIN_W       = 72;
	localparam int DIG_W       = 18;
	localparam int N_DIG       = WIN_W / DIG_W;
	localparam int DIG_CNT_W   = 2;
	localparam int REM_W       = 10;
	localparam int CHUNK_W     = REM_W + DIG_W;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam int QD_W        = CHUNK_W + 1;
	localparam int SHIFT_1E4   = 4;
	localparam int SHIFT_1E3   = 3;

	// floor(2^30 / odd part)
	localparam logic [RECIP_W-1:0] RECIP_1E4 = 24'd1717986;
	localparam logic [RECIP_W-1:0] RECIP_1E3 = 24'd8589934;
	localparam logic [QD_W-1:0]    ODD_1E4   = 29'd625;
	localparam logic [QD_W-1:0]    ODD_1E3   = 29'd125;

	// rounding offsets and output limits
	localparam logic signed [NUM_W-1:0] STEP_HALF  = 73'sd5000;
	localparam logic signed [NUM_W-1:0] CENTI_HALF = 73'sd5000000;
	localparam logic signed [NUM_W-1:0] TEMP_MIN   = -73'sd20500;
	localparam logic signed [NUM_W-1:0] TEMP_MAX   = 73'sd137500;

	// inclusive voltage bounds in uV, checked in order
	localparam logic signed [X_W-1:0] RANGE_LO [ROM_RANGES] =
		'{-17'sd5891, 17'sd0, 17'sd20644, 17'sd0};
	localparam logic signed [X_W-1:0] RANGE_HI [ROM_RANGES] =
		'{17'sd0, 17'sd20644, 17'sd54886, 17'sd0};

	// inverse coefficients d_k scaled by 10^(9+k)
	localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_RANGES][ROM_COEFFS] = '{
		'{48'sd0, 48'sd251734620000, -48'sd116628780000, -48'sd1083363800000,
		  -48'sd8977354000000, -48'sd37342377000000, -48'sd86632643000000,
		  -48'sd104505980000000, -48'sd51920577000000, 48'sd0,
		  48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
		'{48'sd0, 48'sd250835500000, 48'sd7860106000, -48'sd250313100000,
		  48'sd831527000000, -48'sd1228034000000, 48'sd980403600000,
		  -48'sd441303000000, 48'sd105773400000, -48'sd10527550000,
		  48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
		'{-48'sd131805800000, 48'sd483022200000, -48'sd164603100000,
		  48'sd54647310000, -48'sd9650715000, 48'sd880219300, -48'sd31108100,
		  48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
		'{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
		  48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0}
	};

	function automatic logic signed [COEF_W-1:0] coef(
		input logic [RSEL_W-1:0] r,
		input logic [CIDX_W-1:0] k
	);
		return COEF_ROM[r][k];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FOLD,
		ST_DIV_A,
		ST_DIV_B,
		ST_DIV_END,
		ST_ROUND,
		ST_SCALE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PASS_STEP,
		PASS_ROUND,
		PASS_SCALE
	} pass_t;

endpackage

// ===== rtl/core/tkv_mul.sv =====
// Shared registered signed multiplier of the converter.
// Serves the Horner partial products and the divider's reciprocal step.
// Depends on tkv_pkg for operand widths.
module tkv_mul (
	input  logic                              clk,
	input  logic signed [tkv_pkg::MUL_A_W-1:0] a,
	input  logic signed [tkv_pkg::MUL_B_W-1:0] b,
	output logic signed [tkv_pkg::PROD_W-1:0]  p
);

	logic signed [tkv_pkg::PROD_W-1:0] p_q;

	// register the full-width product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/core/thermocouple_k_voltage_to_temp.sv =====
// Type K thermocouple: microvolts to hundredths of a degree C (inverse polynomial).
// In range, the result follows the Horner steps and then the rounding and scaling divides;
// out of range, it goes straight to emit with in_range low. The input takes the next transfer
// in the cycle after the result is loaded; each Horner step is set by two passes through the
// shared multiplier and a four-digit floor divide by 10^4. Reset clears the sequencer and
// the output valid; no other state is kept between items.
module thermocouple_k_voltage_to_temp #(
	parameter int COEFFS_PER_RANGE = tkv_pkg::DEF_COEFFS_PER_RANGE,
	parameter int RANGE_COUNT      = tkv_pkg::DEF_RANGE_COUNT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [tkv_pkg::X_W-1:0] microvolts,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           in_range,
	output logic signed [tkv_pkg::T_W-1:0] temperature_centi
);

	localparam int KW = (COEFFS_PER_RANGE > 2) ? $clog2(COEFFS_PER_RANGE - 1) : 1;

	tkv_pkg::state_t state_q, state_d;
	tkv_pkg::pass_t  pass_q;

	// item registers
	logic signed [tkv_pkg::X_W-1:0]    x_q;
	logic [tkv_pkg::RSEL_W-1:0]        sel_q;
	logic [KW-1:0]                     k_q;
	logic signed [tkv_pkg::ACC_W-1:0]  acc_q;
	logic signed [tkv_pkg::PROD_W-1:0] plo_q;

	// divider registers
	logic                              div_hi_q;
	logic                              neg_q;
	logic [tkv_pkg::WIN_W-1:0]         win_q;
	logic [tkv_pkg::WIN_W-1:0]         quo_q;
	logic [tkv_pkg::REM_W-1:0]         rem_q;
	logic [tkv_pkg::CHUNK_W-1:0]       chunk_q;
	logic [tkv_pkg::DIG_CNT_W-1:0]     dig_q;

	// result and output registers
	logic                              res_hit_q;
	logic signed [tkv_pkg::T_W-1:0]    res_t_q;
	logic                              out_valid_q;
	logic                              out_hit_q;
	logic signed [tkv_pkg::T_W-1:0]    out_t_q;

	// combinational signals
	logic                              in_hit;
	logic [tkv_pkg::RSEL_W-1:0]        in_sel;
	logic signed [tkv_pkg::MUL_A_W-1:0] mul_a;
	logic signed [tkv_pkg::MUL_B_W-1:0] mul_b;
	logic signed [tkv_pkg::PROD_W-1:0] mul_p;
	logic signed [tkv_pkg::NUM_W-1:0]  n_fold;
	logic signed [tkv_pkg::NUM_W-1:0]  n_load;
	logic                              load_hi;
	logic [tkv_pkg::NUM_W-1:0]         n_mag;
	logic [tkv_pkg::WIN_W-1:0]         win_load;
	logic [tkv_pkg::CHUNK_W-1:0]       chunk;
	logic [tkv_pkg::DIG_W-1:0]         q0;
	logic [tkv_pkg::DIG_W-1:0]         q1;
	logic [tkv_pkg::QD_W-1:0]          q0_ext;
	logic [tkv_pkg::QD_W-1:0]          q0_prod;
	logic [tkv_pkg::QD_W-1:0]          odd;
	logic [tkv_pkg::QD_W-1:0]          remv;
	logic [tkv_pkg::QD_W-1:0]          rem_fix;
	logic                              fix;
	logic signed [tkv_pkg::NUM_W-1:0]  qres;
	logic signed [tkv_pkg::NUM_W-1:0]  step_sum;
	logic signed [tkv_pkg::COEF_W-1:0] cur_coef;
	logic signed [tkv_pkg::T_W-1:0]    t_sat;
	logic                              out_free;

	tkv_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// pick the first range that holds the incoming voltage
	always_comb begin
		in_hit = 1'b0;
		in_sel = '0;
		for (int r = RANGE_COUNT - 1; r >= 0; r--) begin
			if (microvolts >= tkv_pkg::RANGE_LO[r] && microvolts <= tkv_pkg::RANGE_HI[r]) begin
				in_hit = 1'b1;
				in_sel = tkv_pkg::RSEL_W'(r);
			end
		end
	end

	// Horner product acc * x, rebuilt from the two partial products, plus rounding half
	assign n_fold = ({{(tkv_pkg::NUM_W - tkv_pkg::PROD_W){mul_p[tkv_pkg::PROD_W-1]}}, mul_p}
			<<< tkv_pkg::LO_W)
		+ {{(tkv_pkg::NUM_W - tkv_pkg::PROD_W){plo_q[tkv_pkg::PROD_W-1]}}, plo_q}
		+ tkv_pkg::STEP_HALF;

	// numerator and divisor for the next floor divide
	always_comb begin
		unique case (state_q)
			tkv_pkg::ST_FOLD: begin
				n_load  = n_fold;
				load_hi = 1'b1;
			end
			tkv_pkg::ST_ROUND: begin
				n_load  = {{(tkv_pkg::NUM_W - tkv_pkg::ACC_W){acc_q[tkv_pkg::ACC_W-1]}}, acc_q}
					+ tkv_pkg::CENTI_HALF;
				load_hi = 1'b1;
			end
			default: begin
				n_load  = {{(tkv_pkg::NUM_W - tkv_pkg::ACC_W){acc_q[tkv_pkg::ACC_W-1]}}, acc_q};
				load_hi = 1'b0;
			end
		endcase
	end

	// fold the sign (floor of a negative n is ~floor(~n / d)) and drop the power of two
	assign n_mag    = n_load[tkv_pkg::NUM_W-1] ? ~n_load : n_load;
	assign win_load = load_hi ? (n_mag[tkv_pkg::WIN_W-1:0] >> tkv_pkg::SHIFT_1E4)
	                          : (n_mag[tkv_pkg::WIN_W-1:0] >> tkv_pkg::SHIFT_1E3);

	// one quotient digit: reciprocal estimate, then a single correction
	assign chunk   = {rem_q, win_q[tkv_pkg::WIN_W-1 -: tkv_pkg::DIG_W]};
	assign q0      = mul_p[tkv_pkg::RECIP_SHIFT +: tkv_pkg::DIG_W];
	assign q0_ext  = {{(tkv_pkg::QD_W - tkv_pkg::DIG_W){1'b0}}, q0};
	assign odd     = div_hi_q ? tkv_pkg::ODD_1E4 : tkv_pkg::ODD_1E3;
	assign q0_prod = div_hi_q ? (q0_ext * tkv_pkg::ODD_1E4) : (q0_ext * tkv_pkg::ODD_1E3);
	assign remv    = {1'b0, chunk_q} - q0_prod;
	assign fix     = (remv >= odd);
	assign q1      = fix ? (q0 + tkv_pkg::DIG_W'(1)) : q0;
	assign rem_fix = fix ? (remv - odd) : remv;

	// signed quotient and what it feeds
	assign qres     = neg_q ? ~{1'b0, quo_q} : {1'b0, quo_q};
	assign cur_coef = tkv_pkg::coef(sel_q, tkv_pkg::CIDX_W'(k_q));
	assign step_sum = {{(tkv_pkg::NUM_W - tkv_pkg::COEF_W){cur_coef[tkv_pkg::COEF_W-1]}},
		cur_coef} + qres;

	// clamp to the output range
	always_comb begin
		priority if (qres < tkv_pkg::TEMP_MIN) begin
			t_sat = tkv_pkg::TEMP_MIN[tkv_pkg::T_W-1:0];
		end else if (qres > tkv_pkg::TEMP_MAX) begin
			t_sat = tkv_pkg::TEMP_MAX[tkv_pkg::T_W-1:0];
		end else begin
			t_sat = qres[tkv_pkg::T_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			tkv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_hit ? tkv_pkg::ST_MUL_LO : tkv_pkg::ST_EMIT;
				end
			end
			tkv_pkg::ST_MUL_LO: begin
				mul_a   = {1'b0, acc_q[tkv_pkg::LO_W-1:0]};
				mul_b   = {{(tkv_pkg::MUL_B_W - tkv_pkg::X_W){x_q[tkv_pkg::X_W-1]}}, x_q};
				state_d = tkv_pkg::ST_MUL_HI;
			end
			tkv_pkg::ST_MUL_HI: begin
				mul_a   = {acc_q[tkv_pkg::ACC_W-1], acc_q[tkv_pkg::ACC_W-1:tkv_pkg::LO_W]};
				mul_b   = {{(tkv_pkg::MUL_B_W - tkv_pkg::X_W){x_q[tkv_pkg::X_W-1]}}, x_q};
				state_d = tkv_pkg::ST_FOLD;
			end
			tkv_pkg::ST_FOLD, tkv_pkg::ST_ROUND, tkv_pkg::ST_SCALE: begin
				state_d = tkv_pkg::ST_DIV_A;
			end
			tkv_pkg::ST_DIV_A: begin
				mul_a   = {1'b0, chunk};
				mul_b   = {1'b0, div_hi_q ? tkv_pkg::RECIP_1E4 : tkv_pkg::RECIP_1E3};
				state_d = tkv_pkg::ST_DIV_B;
			end
			tkv_pkg::ST_DIV_B: begin
				state_d = (dig_q == tkv_pkg::DIG_CNT_W'(tkv_pkg::N_DIG - 1))
					? tkv_pkg::ST_DIV_END : tkv_pkg::ST_DIV_A;
			end
			tkv_pkg::ST_DIV_END: begin
				unique case (pass_q)
					tkv_pkg::PASS_STEP: begin
						state_d = (k_q == '0) ? tkv_pkg::ST_ROUND : tkv_pkg::ST_MUL_LO;
					end
					tkv_pkg::PASS_ROUND: state_d = tkv_pkg::ST_SCALE;
					tkv_pkg::PASS_SCALE: state_d = tkv_pkg::ST_EMIT;
					default:             state_d = tkv_pkg::ST_IDLE;
				endcase
			end
			tkv_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = tkv_pkg::ST_IDLE;
				end
			end
			default: state_d = tkv_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tkv_pkg::ST_IDLE: begin
				if (in_valid) begin
					x_q       <= microvolts;
					sel_q     <= in_sel;
					k_q       <= KW'(COEFFS_PER_RANGE - 2);
					acc_q     <= tkv_pkg::ACC_W'(tkv_pkg::coef(in_sel,
						tkv_pkg::CIDX_W'(COEFFS_PER_RANGE - 1)));
					pass_q    <= tkv_pkg::PASS_STEP;
					res_hit_q <= 1'b0;
					res_t_q   <= '0;
				end
			end
			tkv_pkg::ST_MUL_HI: begin
				plo_q <= mul_p;
			end
			tkv_pkg::ST_FOLD, tkv_pkg::ST_ROUND, tkv_pkg::ST_SCALE: begin
				div_hi_q <= load_hi;
				neg_q    <= n_load[tkv_pkg::NUM_W-1];
				win_q    <= win_load;
				rem_q    <= '0;
				dig_q    <= '0;
				if (state_q == tkv_pkg::ST_ROUND) begin
					pass_q <= tkv_pkg::PASS_ROUND;
				end else if (state_q == tkv_pkg::ST_SCALE) begin
					pass_q <= tkv_pkg::PASS_SCALE;
				end
			end
			tkv_pkg::ST_DIV_A: begin
				chunk_q <= chunk;
			end
			tkv_pkg::ST_DIV_B: begin
				quo_q <= {quo_q[tkv_pkg::WIN_W-tkv_pkg::DIG_W-1:0], q1};
				rem_q <= rem_fix[tkv_pkg::REM_W-1:0];
				win_q <= win_q << tkv_pkg::DIG_W;
				dig_q <= dig_q + tkv_pkg::DIG_CNT_W'(1);
			end
			tkv_pkg::ST_DIV_END: begin
				unique case (pass_q)
					tkv_pkg::PASS_STEP: begin
						acc_q <= step_sum[tkv_pkg::ACC_W-1:0];
						k_q   <= k_q - KW'(1);
					end
					tkv_pkg::PASS_ROUND: begin
						acc_q <= qres[tkv_pkg::ACC_W-1:0];
					end
					tkv_pkg::PASS_SCALE: begin
						res_hit_q <= 1'b1;
						res_t_q   <= t_sat;
					end
					default: begin
						res_hit_q <= 1'b0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// output register: load on emit, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tkv_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (state_q == tkv_pkg::ST_EMIT && out_free) begin
			out_hit_q <= res_hit_q;
			out_t_q   <= res_t_q;
		end
	end

	assign in_stall          = (state_q != tkv_pkg::ST_IDLE);
	assign out_valid         = out_valid_q;
	assign in_range          = out_hit_q;
	assign temperature_centi = out_t_q;

endmodule
